### hw/rtl/kmds_pkg.sv
`default_nettype none

package kmds_pkg;

  // Fixed field widths of the channels.
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int LEVELS_W   = 8;
  localparam int CHAR_W     = 8;
  localparam int MAP_W      = 64;
  localparam int CFG_IDX_W  = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK
  } kmds_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic update;      // apply the accepted row sample
    logic copy;        // take the pressed flags as reported
    logic walk_start;  // clear the walk position
    logic step;        // move the walk position to the next key
    logic load;        // load the output register with the current key
  } kmds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_end;   // sampled row is the last row
    logic changed;     // pressed flags differ from the reported ones
    logic cur_pressed; // key at the walk position is pressed
    logic walk_end;    // walk position is the last key
    logic out_free;    // output register can take a word this cycle
  } kmds_status_t;

endpackage

`default_nettype wire

### hw/rtl/kmds_if.sv
`default_nettype none

interface kmds_sample_if;
  logic                          valid;
  logic                          ready;
  logic [kmds_pkg::ROW_W-1:0]    scan_row;
  logic [kmds_pkg::LEVELS_W-1:0] column_levels;

  modport source (output valid, output scan_row, output column_levels, input ready);
  modport sink   (input valid, input scan_row, input column_levels, output ready);
endinterface

interface kmds_report_if;
  logic                        valid;
  logic                        ready;
  logic [kmds_pkg::CHAR_W-1:0] key_char;
  logic [kmds_pkg::ROW_W-1:0]  key_row;
  logic [kmds_pkg::COL_W-1:0]  key_col;
  logic                        last_key;

  modport source (output valid, output key_char, output key_row, output key_col,
                  output last_key, input ready);
  modport sink   (input valid, input key_char, input key_row, input key_col,
                  input last_key, output ready);
endinterface

interface kmds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kmds_pkg::CFG_IDX_W-1:0] reg_index;
  logic [kmds_pkg::MAP_W-1:0]     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/kmds_ctrl.sv
`default_nettype none

module kmds_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   sample_valid,
  output logic                  sample_ready,
  input  kmds_pkg::kmds_status_t status,
  output kmds_pkg::kmds_cmd_t   cmd
);

  kmds_pkg::kmds_state_t state;
  kmds_pkg::kmds_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    cmd          = '0;
    case (state)
      kmds_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.update = 1'b1;
          if (status.frame_end) begin
            state_next = kmds_pkg::ST_CHECK;
          end
        end
      end
      kmds_pkg::ST_CHECK: begin
        if (status.changed) begin
          cmd.copy       = 1'b1;
          cmd.walk_start = 1'b1;
          state_next     = kmds_pkg::ST_WALK;
        end else begin
          state_next = kmds_pkg::ST_IDLE;
        end
      end
      kmds_pkg::ST_WALK: begin
        // A pressed key waits until the output register is free.
        if (!status.cur_pressed || status.out_free) begin
          cmd.step = 1'b1;
          cmd.load = status.cur_pressed;
          if (status.walk_end) begin
            state_next = kmds_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = kmds_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/kmds_datapath.sv
`default_nettype none

module kmds_datapath #(
  parameter int ROWS        = 8,
  parameter int COLS        = 8,
  parameter int COUNT_LIMIT = 6,
  parameter int CW          = 3,
  parameter int RIW         = 3,
  parameter int CIW         = 3
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire [kmds_pkg::ROW_W-1:0]          scan_row,
  input  wire [kmds_pkg::LEVELS_W-1:0]       column_levels,
  input  kmds_pkg::kmds_cmd_t                cmd,
  output kmds_pkg::kmds_status_t             status,
  kmds_cfg_if.sink                           cfg,
  kmds_report_if.source                      report
);

  localparam int KEYS          = ROWS * COLS;
  localparam int KW            = $clog2(KEYS + 1);
  localparam int PRESS_ABOVE   = (COUNT_LIMIT / 2) + 1;
  localparam int RELEASE_BELOW = (COUNT_LIMIT / 2) - 1;

  localparam logic [CW-1:0] LIMIT_C   = CW'(COUNT_LIMIT);
  localparam logic [CW-1:0] PRESS_C   = CW'(PRESS_ABOVE);
  localparam logic [CW-1:0] RELEASE_C = CW'(RELEASE_BELOW);

  logic [COLS-1:0][CW-1:0]   counters [ROWS];
  logic [ROWS-1:0][COLS-1:0] pressed;
  logic [ROWS-1:0][COLS-1:0] reported;
  logic [kmds_pkg::MAP_W-1:0] key_map [ROWS];

  logic [RIW-1:0] walk_row;
  logic [CIW-1:0] walk_col;

  logic                        out_valid;
  logic [kmds_pkg::CHAR_W-1:0] out_char;
  logic [kmds_pkg::ROW_W-1:0]  out_row;
  logic [kmds_pkg::COL_W-1:0]  out_col;
  logic                        out_last;

  logic                      row_ok;
  logic [RIW-1:0]            row_idx;
  logic [COLS-1:0][CW-1:0]   row_cnt;
  logic [COLS-1:0][CW-1:0]   row_cnt_next;
  logic [COLS-1:0]           row_flags_next;
  logic [KEYS-1:0]           flat_flags;
  logic [KW-1:0]             key_idx;
  logic                      cur_last;

  assign row_ok  = 32'(scan_row) < ROWS;
  assign row_idx = scan_row[RIW-1:0];
  assign row_cnt = counters[row_idx];

  // Saturating counter step and hysteresis for every column of the row.
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      if (column_levels[c]) begin
        row_cnt_next[c] = (row_cnt[c] < LIMIT_C) ? row_cnt[c] + 1'b1 : LIMIT_C;
      end else begin
        row_cnt_next[c] = (row_cnt[c] != '0) ? row_cnt[c] - 1'b1 : '0;
      end
      if (row_cnt_next[c] > PRESS_C) begin
        row_flags_next[c] = 1'b1;
      end else if (row_cnt_next[c] < RELEASE_C) begin
        row_flags_next[c] = 1'b0;
      end else begin
        row_flags_next[c] = pressed[row_idx][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        counters[r] <= '0;
      end
      pressed  <= '0;
      reported <= '0;
    end else begin
      if (cmd.update && row_ok) begin
        counters[row_idx] <= row_cnt_next;
        pressed[row_idx]  <= row_flags_next;
      end
      if (cmd.copy) begin
        reported <= pressed;
      end
    end
  end

  // Key map registers; writes to rows that do not exist are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        key_map[r] <= '0;
      end
    end else if (cfg.valid && 32'(cfg.reg_index) < ROWS) begin
      key_map[cfg.reg_index[RIW-1:0]] <= cfg.wdata;
    end
  end

  // Walk position over the matrix in row-major order.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_row <= '0;
      walk_col <= '0;
    end else if (cmd.walk_start) begin
      walk_row <= '0;
      walk_col <= '0;
    end else if (cmd.step) begin
      if (walk_col == CIW'(COLS - 1)) begin
        walk_col <= '0;
        walk_row <= walk_row + 1'b1;
      end else begin
        walk_col <= walk_col + 1'b1;
      end
    end
  end

  // The current key is the last report when no pressed key follows it.
  assign flat_flags = pressed;
  assign key_idx    = KW'(walk_row) * KW'(COLS) + KW'(walk_col);
  assign cur_last   = ((flat_flags >> key_idx) >> 1) == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_char <= key_map[walk_row][{walk_col, 3'b000} +: kmds_pkg::CHAR_W];
      out_row  <= kmds_pkg::ROW_W'(walk_row);
      out_col  <= kmds_pkg::COL_W'(walk_col);
      out_last <= cur_last;
    end
  end

  assign report.valid    = out_valid;
  assign report.key_char = out_char;
  assign report.key_row  = out_row;
  assign report.key_col  = out_col;
  assign report.last_key = out_last;

  assign status.frame_end   = 32'(scan_row) == ROWS - 1;
  assign status.changed     = pressed != reported;
  assign status.cur_pressed = pressed[walk_row][walk_col];
  assign status.walk_end    = (walk_row == RIW'(ROWS - 1)) && (walk_col == CIW'(COLS - 1));
  assign status.out_free    = !out_valid || report.ready;

endmodule

`default_nettype wire

### hw/rtl/key_matrix_debounce_scanner_top.sv
`default_nettype none

// Debounced keypad matrix scanner. Each sample word carries one row number and
// the levels of all columns of that row. Every key has a saturating counter
// that rises while the key reads high and falls while it reads low; a key turns
// pressed above COUNT_LIMIT/2+1 and released below COUNT_LIMIT/2-1. A sample of
// the last row ends a frame: if any pressed flag changed since the last report,
// one report word is sent for every pressed key in row-major order, carrying
// the character from the key map registers, the row, the column and a flag on
// the final word of the frame. A row sample is applied as it is accepted. A
// frame end adds a compare step and, when the flags changed, a walk over all
// ROWS*COLS keys at one key per cycle, held while a pressed key waits for a
// stalled report side. Sample words are not taken during the compare and the
// walk, but a finished report word may wait in the output register while new
// samples are taken. Key map writes are always accepted; writes to a register
// index of ROWS or more have no effect.

module key_matrix_debounce_scanner_top #(
  parameter int ROWS        = 8,
  parameter int COLS        = 8,
  parameter int COUNT_LIMIT = 6
) (
  input  wire           clk,
  input  wire           rst,
  kmds_sample_if.sink   sample,
  kmds_report_if.source report,
  kmds_cfg_if.sink      cfg
);

  // Counter width covers the saturation limit; row and column indexes are as
  // narrow as the matrix allows, with at least one bit.
  localparam int CW  = $clog2(COUNT_LIMIT + 1);
  localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;

  kmds_pkg::kmds_cmd_t    cmd;
  kmds_pkg::kmds_status_t status;
  logic                   sample_ready;

  assign sample.ready = sample_ready;

  // The controller sequences sample updates, the frame-end compare and the
  // walk over the keys.
  kmds_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // The datapath holds the counters, the flags, the key map and the output
  // register.
  kmds_datapath #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .COUNT_LIMIT (COUNT_LIMIT),
    .CW          (CW),
    .RIW         (RIW),
    .CIW         (CIW)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .scan_row      (sample.scan_row),
    .column_levels (sample.column_levels),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .report        (report)
  );

endmodule

`default_nettype wire

### bench/tb_key_matrix_debounce_scanner_top.sv
`default_nettype none

// Bench for the debounced keypad matrix scanner. Row sample words go in, key
// report words come out, and key map registers are written through their own
// channel. A local model of the debounce counters, the pressed flags and the
// flags of the last report runs on every accepted sample word and queues the
// report words it expects; a monitor pops them in order as the block sends.

module tb_key_matrix_debounce_scanner_top;

  localparam int ROWS          = 8;
  localparam int COLS          = 8;
  localparam int COUNT_LIMIT   = 6;
  localparam int MAX_KEYS      = 64;
  localparam int PRESS_ABOVE   = COUNT_LIMIT / 2 + 1;
  localparam int RELEASE_BELOW = COUNT_LIMIT / 2 - 1;
  localparam int CFG_IDX_TOP   = (1 << kmds_pkg::CFG_IDX_W) - 1;

  // A frame end with changed flags walks every key once, even when it ends up
  // reporting nothing, so an idle check waits out one walk plus some margin.
  localparam int SETTLE_CYCLES = ROWS * COLS + 16;

  // Roughly 200 words, each of which could in the worst case trigger a full
  // walk of 64 reports under random stalls, plus one long hold and the settle
  // pauses. The limit below is several times that.
  localparam int CYCLE_LIMIT        = 200000;
  localparam int REPORT_HOLD_CYCLES = 300;

  typedef logic [kmds_pkg::ROW_W-1:0]     row_t;
  typedef logic [kmds_pkg::LEVELS_W-1:0]  levels_t;
  typedef logic [kmds_pkg::CFG_IDX_W-1:0] index_t;

  typedef struct packed {
    logic [kmds_pkg::CHAR_W-1:0] key_char;
    logic [kmds_pkg::ROW_W-1:0]  key_row;
    logic [kmds_pkg::COL_W-1:0]  key_col;
    logic                        last_key;
  } key_report_t;

  typedef enum {
    MAP_RANDOM,
    MAP_ALL_ONES,
    MAP_ZERO
  } map_style_t;

  logic clk = 1'b0;
  logic rst;

  kmds_sample_if sample_ch ();
  kmds_report_if report_ch ();
  kmds_cfg_if    cfg_ch ();

  key_matrix_debounce_scanner_top #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .COUNT_LIMIT (COUNT_LIMIT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .report (report_ch),
    .cfg    (cfg_ch)
  );

  always #1 clk = ~clk;

  // Local copy of the block's state, updated only when a word is accepted.
  logic [kmds_pkg::MAP_W-1:0] key_map_shadow [ROWS];
  logic [2:0]                 press_count [MAX_KEYS];
  logic [MAX_KEYS-1:0]        pressed_now;
  logic [MAX_KEYS-1:0]        pressed_told;
  key_report_t                expected_keys [$];

  int unsigned mismatches   = 0;
  int unsigned words_sent;
  int unsigned reports_seen = 0;
  int unsigned map_writes;
  int unsigned cycle_count  = 0;

  // Shared by the sender and the receiver: while set, neither side idles.
  logic no_gaps;
  // Raised by its own process on report_hold_ev to starve the block of report
  // bandwidth.
  logic report_hold;
  event report_hold_ev;

  // Debounce one row sample and, at a frame end with changed flags, queue one
  // report word per pressed key in row-major order.
  function automatic void predict_sample(input row_t    row,
                                         input levels_t levels);
    int          key;
    int          total;
    int          emitted;
    key_report_t rep;
    if (row >= ROWS) return;
    for (int c = 0; c < COLS; c++) begin
      key = row * 8 + c;
      if (levels[c]) begin
        if (press_count[key] < COUNT_LIMIT) press_count[key] = press_count[key] + 3'd1;
      end else if (press_count[key] > 0) begin
        press_count[key] = press_count[key] - 3'd1;
      end
      // Between the two thresholds the flag keeps its old value.
      if (press_count[key] > PRESS_ABOVE) pressed_now[key] = 1'b1;
      else if (press_count[key] < RELEASE_BELOW) pressed_now[key] = 1'b0;
    end
    if (row != ROWS - 1 || pressed_now == pressed_told) return;
    // A change always refreshes the reported flags, even when no key is left
    // pressed and so no word goes out.
    pressed_told = pressed_now;
    total = $countones(pressed_now);
    emitted = 0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        key = r * 8 + c;
        if (pressed_now[key]) begin
          emitted++;
          rep.key_char = key_map_shadow[r][8*c +: 8];
          rep.key_row  = r[kmds_pkg::ROW_W-1:0];
          rep.key_col  = c[kmds_pkg::COL_W-1:0];
          rep.last_key = (emitted == total);
          expected_keys.push_back(rep);
        end
      end
    end
  endfunction

  // Send one sample word. Random idle cycles go in front of it; valid stays
  // high afterwards so back-to-back words keep it up without a dip.
  task automatic send_sample(input row_t    row,
                             input levels_t levels);
    while (!no_gaps && $urandom_range(99) < 20) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.scan_row      <= row;
    sample_ch.column_levels <= levels;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    words_sent++;
    predict_sample(row, levels);
  endtask

  // Stop sending, let every expected report arrive, then wait out a walk that
  // may still be running without any report to show for it.
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_map(input index_t                     index,
                               input logic [kmds_pkg::MAP_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= index;
    cfg_ch.wdata     <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (index < ROWS) key_map_shadow[index] = value;
    map_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Rewrite the whole key map, then write one random index beyond the last row,
  // which the block must ignore.
  task automatic program_key_map(input map_style_t style);
    logic [kmds_pkg::MAP_W-1:0] value;
    index_t                     spare_index;
    for (int i = 0; i < ROWS; i++) begin
      if (style == MAP_ALL_ONES) value = '1;
      else if (style == MAP_ZERO) value = '0;
      else value = {$urandom, $urandom};
      write_key_map(index_t'(i), value);
    end
    spare_index = index_t'($urandom_range(CFG_IDX_TOP, ROWS));
    write_key_map(spare_index, {$urandom, $urandom});
  endtask

  // Hold the whole last row high until its counters saturate, then low until
  // they fall through the release threshold. The release leaves no key pressed,
  // so the flags change but nothing is reported.
  task automatic test_row_seven_press_release();
    repeat (6) send_sample(row_t'(ROWS - 1), '1);
    repeat (5) send_sample(row_t'(ROWS - 1), '0);
  endtask

  // Rows out of scan order: row 0 is pressed on its own, and only the next
  // sample of the last row brings out the report. Middle rows get one sample each
  // of a mixed bit pattern, which cannot press anything.
  task automatic test_rows_out_of_order();
    repeat (5) send_sample(3'd0, 8'h81);
    send_sample(3'd5, 8'h55);
    send_sample(3'd6, 8'hAA);
    send_sample(row_t'(ROWS - 1), '0);
    send_sample(3'd2, 8'h3C);
    send_sample(row_t'(ROWS - 1), '0);
  endtask

  // Every key goes high for whole frames while the receiver is held off, so a
  // full walk of 64 reports jams the output and the block stops taking
  // samples. Afterwards the sender pauses until every report has come.
  task automatic test_report_backpressure();
    -> report_hold_ev;
    repeat (5) begin
      for (int r = 0; r < ROWS; r++) send_sample(row_t'(r), '1);
    end
    wait_idle();
  endtask

  // Scan sessions: each picks a steady level pattern per row and holds it for
  // a few ordered frames with the odd bouncing bit. Some frames are replaced
  // by a burst of samples on random rows.
  task automatic test_random_frames(input int words);
    levels_t held [ROWS];
    levels_t levels;
    int      sent;
    int      pick;
    sent = 0;
    while (sent < words) begin
      for (int r = 0; r < ROWS; r++) begin
        pick = $urandom_range(7);
        if (pick == 0) held[r] = '1;
        else if (pick == 1) held[r] = '0;
        else held[r] = levels_t'($urandom & $urandom);
      end
      repeat ($urandom_range(6, 2)) begin
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(3, 1)) begin
            send_sample(row_t'($urandom_range(ROWS - 1)), levels_t'($urandom));
            sent++;
          end
        end else begin
          for (int r = 0; r < ROWS; r++) begin
            levels = held[r];
            if ($urandom_range(7) == 0) levels[$urandom_range(COLS - 1)] ^= 1'b1;
            send_sample(row_t'(r), levels);
            sent++;
          end
        end
      end
    end
  endtask

  // Receiver: ready drops about one cycle in five, never while the no-gap
  // stretch runs, and stays low for the whole report hold.
  always @(posedge clk) begin
    if (rst || report_hold) begin
      report_ch.ready <= 1'b0;
    end else if (no_gaps) begin
      report_ch.ready <= 1'b1;
    end else begin
      report_ch.ready <= ($urandom_range(99) >= 20);
    end
  end

  initial begin
    report_hold <= 1'b0;
    forever begin
      @(report_hold_ev);
      report_hold <= 1'b1;
      repeat (REPORT_HOLD_CYCLES) @(posedge clk);
      report_hold <= 1'b0;
    end
  end

  // Each accepted report word is checked field by field against the oldest
  // word still expected.
  key_report_t want;

  always @(posedge clk) begin
    if (!rst && report_ch.valid && report_ch.ready) begin
      reports_seen++;
      if (expected_keys.size() == 0) begin
        $error("unexpected report word: key_char %0d row %0d col %0d last %0d",
               report_ch.key_char, report_ch.key_row, report_ch.key_col,
               report_ch.last_key);
        mismatches++;
      end else begin
        want = expected_keys.pop_front();
        if (report_ch.key_char !== want.key_char) begin
          $error("key_char: expected %0d, got %0d", want.key_char, report_ch.key_char);
          mismatches++;
        end
        if (report_ch.key_row !== want.key_row) begin
          $error("key_row: expected %0d, got %0d", want.key_row, report_ch.key_row);
          mismatches++;
        end
        if (report_ch.key_col !== want.key_col) begin
          $error("key_col: expected %0d, got %0d", want.key_col, report_ch.key_col);
          mismatches++;
        end
        if (report_ch.last_key !== want.last_key) begin
          $error("last_key: expected %0d, got %0d", want.last_key, report_ch.last_key);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d report words outstanding.",
               cycle_count, expected_keys.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    words_sent   = 0;
    map_writes   = 0;
    pressed_now  = '0;
    pressed_told = '0;
    for (int i = 0; i < ROWS; i++) key_map_shadow[i] = '0;
    for (int k = 0; k < MAX_KEYS; k++) press_count[k] = '0;

    rst                     <= 1'b1;
    no_gaps                 <= 1'b0;
    sample_ch.valid         <= 1'b0;
    sample_ch.scan_row      <= '0;
    sample_ch.column_levels <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.reg_index        <= '0;
    cfg_ch.wdata            <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    program_key_map(MAP_RANDOM);
    test_row_seven_press_release();
    test_rows_out_of_order();
    wait_idle();

    test_report_backpressure();

    program_key_map(MAP_ALL_ONES);
    test_random_frames(30);
    wait_idle();

    // A stretch with no idling on either side.
    no_gaps <= 1'b1;
    program_key_map(MAP_RANDOM);
    test_random_frames(30);
    wait_idle();
    no_gaps <= 1'b0;

    program_key_map(MAP_ZERO);
    test_random_frames(30);
    wait_idle();

    $display("Run covered %0d row samples, %0d key reports and %0d key map writes,",
             words_sent, reports_seen, map_writes);
    $display("including one %0d-cycle report hold and a no-idle stretch.",
             REPORT_HOLD_CYCLES);
    if (mismatches == 0 && expected_keys.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
